FILE: rtl/stsl_pkg.sv
// Shared types and constants of the segment triangle slide unit.
package stsl_pkg;

	localparam int COORD_W   = 16;
	localparam int VTX_W     = 3 * COORD_W;
	localparam int CFG_IDX_W = 2;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int CRS_W     = PROD_W + 1;
	localparam int MAG_W     = CRS_W - 1;
	localparam int DOT_W     = 54;
	localparam int SQ_W      = 2 * CRS_W;
	localparam int NN_W      = SQ_W + 2;
	localparam int SPLIT_W   = DOT_W / 2;
	localparam int PPROD_W   = MAG_W + SPLIT_W;
	localparam int NUM_W     = MAG_W + DOT_W;
	localparam int PQB       = 19;
	localparam int RND_W     = PQB + 1;
	localparam int SAT_W     = RND_W + 1;
	localparam int TIME_W    = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX_A = 2'd0,
		REG_VERTEX_B = 2'd1,
		REG_VERTEX_C = 2'd2
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CRS_W-1:0]   crs_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic        [NN_W-1:0]    nn_t;

	typedef struct packed {
		logic         req_type;
		coord_t [2:0] start;
		coord_t [2:0] move;
	} in_item_t;

	typedef struct packed {
		logic         req;
		logic         degen;
		coord_t [2:0] b;
		crs_t   [2:0] n;
		dot_t         nb;
		dot_t         tn;
		dot_t         un;
		dot_t         vn;
		nn_t          nn;
	} front_t;

endpackage

FILE: rtl/stsl_if.sv
// Request, result and register write channels of the segment triangle slide unit.
interface stsl_in_if;
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	stsl_pkg::coord_t      start_x;
	stsl_pkg::coord_t      start_y;
	stsl_pkg::coord_t      start_z;
	stsl_pkg::coord_t      move_x;
	stsl_pkg::coord_t      move_y;
	stsl_pkg::coord_t      move_z;

	modport source (output valid, req_type, start_x, start_y, start_z, move_x, move_y, move_z,
		input ready);
	modport sink (input valid, req_type, start_x, start_y, start_z, move_x, move_y, move_z,
		output ready);
endinterface

interface stsl_out_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [stsl_pkg::TIME_W-1:0]   hit_time;
	stsl_pkg::coord_t              slid_x;
	stsl_pkg::coord_t              slid_y;
	stsl_pkg::coord_t              slid_z;
	logic                          degenerate;

	modport source (output valid, hit, hit_time, slid_x, slid_y, slid_z, degenerate,
		input ready);
	modport sink (input valid, hit, hit_time, slid_x, slid_y, slid_z, degenerate,
		output ready);
endinterface

interface stsl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [stsl_pkg::CFG_IDX_W-1:0] index;
	logic [stsl_pkg::VTX_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/stsl_front.sv
// Geometry front end: edge vectors, cross products, dot products and the normal's square.
module stsl_front #(
	parameter int CWE = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  stsl_pkg::in_item_t         item,
	input  logic [stsl_pkg::VTX_W-1:0] vtx_a,
	input  logic [stsl_pkg::VTX_W-1:0] vtx_b,
	input  logic [stsl_pkg::VTX_W-1:0] vtx_c,
	output stsl_pkg::front_t           res
);
	typedef logic signed [stsl_pkg::DIFF_W-1:0] diff_t;
	typedef logic signed [stsl_pkg::PROD_W-1:0] prod_t;
	typedef logic signed [stsl_pkg::SQ_W-1:0]   sq_t;

	function automatic stsl_pkg::coord_t sext(input logic [stsl_pkg::COORD_W-1:0] raw);
		return stsl_pkg::coord_t'($signed(raw[CWE-1:0]));
	endfunction

	stsl_pkg::coord_t a_c [3];
	diff_t            d_c [3];
	diff_t            e_c [3];
	diff_t            w_c [3];
	stsl_pkg::coord_t b_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_c[k] = sext(vtx_a[stsl_pkg::COORD_W*k +: stsl_pkg::COORD_W]);
			d_c[k] = diff_t'(sext(vtx_b[stsl_pkg::COORD_W*k +: stsl_pkg::COORD_W]))
				- diff_t'(a_c[k]);
			e_c[k] = diff_t'(sext(vtx_c[stsl_pkg::COORD_W*k +: stsl_pkg::COORD_W]))
				- diff_t'(a_c[k]);
			w_c[k] = diff_t'(sext(item.start[k])) - diff_t'(a_c[k]);
			b_c[k] = sext(item.move[k]);
		end
	end

	logic             req_s1;
	stsl_pkg::coord_t b_s1 [3];
	diff_t            d_s1 [3];
	diff_t            e_s1 [3];
	diff_t            w_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1 <= item.req_type;
			for (int k = 0; k < 3; k++) begin
				b_s1[k] <= b_c[k];
				d_s1[k] <= d_c[k];
				e_s1[k] <= e_c[k];
				w_s1[k] <= w_c[k];
			end
		end
	end

	// Cross products N = D x E, W x E and D x W, as left and right partial products.
	logic             req_s2;
	stsl_pkg::coord_t b_s2 [3];
	diff_t            w_s2 [3];
	prod_t            pl_s2 [3][3];
	prod_t            pr_s2 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			req_s2 <= req_s1;
			for (int i = 0; i < 3; i++) begin
				b_s2[i] <= b_s1[i];
				w_s2[i] <= w_s1[i];
				pl_s2[0][i] <= prod_t'(d_s1[(i+1)%3]) * prod_t'(e_s1[(i+2)%3]);
				pr_s2[0][i] <= prod_t'(d_s1[(i+2)%3]) * prod_t'(e_s1[(i+1)%3]);
				pl_s2[1][i] <= prod_t'(w_s1[(i+1)%3]) * prod_t'(e_s1[(i+2)%3]);
				pr_s2[1][i] <= prod_t'(w_s1[(i+2)%3]) * prod_t'(e_s1[(i+1)%3]);
				pl_s2[2][i] <= prod_t'(d_s1[(i+1)%3]) * prod_t'(w_s1[(i+2)%3]);
				pr_s2[2][i] <= prod_t'(d_s1[(i+2)%3]) * prod_t'(w_s1[(i+1)%3]);
			end
		end
	end

	logic             req_s3;
	stsl_pkg::coord_t b_s3 [3];
	diff_t            w_s3 [3];
	stsl_pkg::crs_t   crs_s3 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			req_s3 <= req_s2;
			for (int i = 0; i < 3; i++) begin
				b_s3[i] <= b_s2[i];
				w_s3[i] <= w_s2[i];
				for (int c = 0; c < 3; c++) begin
					crs_s3[c][i] <= stsl_pkg::crs_t'(pl_s2[c][i])
						- stsl_pkg::crs_t'(pr_s2[c][i]);
				end
			end
		end
	end

	logic             req_s4;
	stsl_pkg::coord_t b_s4 [3];
	stsl_pkg::crs_t   n_s4 [3];
	stsl_pkg::dot_t   nbp_s4 [3];
	stsl_pkg::dot_t   tnp_s4 [3];
	stsl_pkg::dot_t   unp_s4 [3];
	stsl_pkg::dot_t   vnp_s4 [3];
	sq_t              sq_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			req_s4 <= req_s3;
			for (int i = 0; i < 3; i++) begin
				b_s4[i]   <= b_s3[i];
				n_s4[i]   <= crs_s3[0][i];
				nbp_s4[i] <= stsl_pkg::dot_t'(crs_s3[0][i]) * stsl_pkg::dot_t'(b_s3[i]);
				tnp_s4[i] <= stsl_pkg::dot_t'(crs_s3[0][i]) * stsl_pkg::dot_t'(w_s3[i]);
				unp_s4[i] <= stsl_pkg::dot_t'(crs_s3[1][i]) * stsl_pkg::dot_t'(b_s3[i]);
				vnp_s4[i] <= stsl_pkg::dot_t'(crs_s3[2][i]) * stsl_pkg::dot_t'(b_s3[i]);
				sq_s4[i]  <= sq_t'(crs_s3[0][i]) * sq_t'(crs_s3[0][i]);
			end
		end
	end

	stsl_pkg::front_t res_c;
	stsl_pkg::front_t res_s5;

	always_comb begin
		res_c.req   = req_s4;
		res_c.degen = (n_s4[0] == '0) && (n_s4[1] == '0) && (n_s4[2] == '0);
		for (int i = 0; i < 3; i++) begin
			res_c.b[i] = b_s4[i];
			res_c.n[i] = n_s4[i];
		end
		res_c.nb = nbp_s4[0] + nbp_s4[1] + nbp_s4[2];
		res_c.tn = stsl_pkg::dot_t'(0) - (tnp_s4[0] + tnp_s4[1] + tnp_s4[2]);
		res_c.un = unp_s4[0] + unp_s4[1] + unp_s4[2];
		res_c.vn = vnp_s4[0] + vnp_s4[1] + vnp_s4[2];
		// Squares are never negative, so they widen with zeros.
		res_c.nn = stsl_pkg::nn_t'($unsigned(sq_s4[0])) + stsl_pkg::nn_t'($unsigned(sq_s4[1]))
			+ stsl_pkg::nn_t'($unsigned(sq_s4[2]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= res_c;
		end
	end

	assign res = res_s5;

endmodule

FILE: rtl/stsl_div.sv
// Pipelined restoring divider, one quotient bit per stage, then pass-through stages up to DEPTH.
module stsl_div #(
	parameter int NW    = 88,
	parameter int DW    = 72,
	parameter int QB    = 19,
	parameter int DEPTH = 19
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo,
	output logic [NW-1:0] rem,
	output logic [DW-1:0] den_o
);
	localparam int CW = (NW > DW + QB) ? NW : DW + QB;

	logic [NW-1:0] rem_sd [DEPTH];
	logic [QB-1:0] quo_sd [DEPTH];
	logic [DW-1:0] den_sd [DEPTH];

	for (genvar j = 0; j < DEPTH; j++) begin : g_st
		logic [NW-1:0] rem_in;
		logic [QB-1:0] quo_in;
		logic [DW-1:0] den_in;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_sd[j-1];
			assign quo_in = quo_sd[j-1];
			assign den_in = den_sd[j-1];
		end

		if (j < QB) begin : g_step
			localparam int POS = QB - 1 - j;
			logic [CW-1:0] rx;
			logic [CW-1:0] dx;
			logic          ge;

			assign rx = CW'(rem_in);
			assign dx = CW'(den_in) << POS;
			assign ge = (rx >= dx);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[j] <= ge ? NW'(rx - dx) : rem_in;
					quo_sd[j] <= quo_in | (ge ? (QB'(1) << POS) : '0);
					den_sd[j] <= den_in;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[j] <= rem_in;
					quo_sd[j] <= quo_in;
					den_sd[j] <= den_in;
				end
			end
		end
	end

	assign quo   = quo_sd[DEPTH-1];
	assign rem   = rem_sd[DEPTH-1];
	assign den_o = den_sd[DEPTH-1];

endmodule

FILE: rtl/segment_triangle_slide_unit.sv
// Top level of the segment triangle slide unit.
//
// The block tests a segment, given as a start point and a move vector in signed Q8.8, against
// the triangle held in three vertex registers, and reports the hit flag, the hit time t in
// unsigned Q1.TIME_FRAC_BITS and the move projected onto the triangle's plane.
// Requests arrive on in_ch and results leave on out_ch, both valid/ready channels; a request
// is taken at a clock edge where valid and ready are both high. Vertex registers are written
// through cfg, which is always ready; they are to be written only while no request is in flight.
// The move is projected only when req_type is set or on a hit, and never for a degenerate
// triangle. One request is taken every cycle while the receiver keeps ready high; the
// pipeline's length is set by the bit-per-stage dividers that produce t and the projection terms.
// When the receiver holds ready low with a result waiting, the whole pipeline freezes, the
// waiting result stays on out_ch and in_ch.ready falls in the same cycle, so nothing is lost.
// Asynchronous reset empties the pipeline and clears the vertex registers to zero.
module segment_triangle_slide_unit #(
	parameter int COORD_WIDTH    = 16,
	parameter int TIME_FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	stsl_cfg_if.sink   cfg,
	stsl_in_if.sink    in_ch,
	stsl_out_if.source out_ch
);
	localparam int CWE    = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
	localparam int TQB    = TIME_FRAC_BITS + 1;
	localparam int DEPTH  = (TQB > stsl_pkg::PQB) ? TQB : stsl_pkg::PQB;
	localparam int TNUM_W = stsl_pkg::DOT_W + TIME_FRAC_BITS;
	localparam int PIPE_N = 11 + DEPTH;

	typedef logic        [stsl_pkg::PPROD_W-1:0] pprod_t;
	typedef logic        [stsl_pkg::NUM_W-1:0]   num_t;
	typedef logic        [stsl_pkg::RND_W-1:0]   rnd_t;
	typedef logic signed [stsl_pkg::SAT_W-1:0]   sat_t;
	typedef logic        [stsl_pkg::TIME_W-1:0]  time_t;

	localparam sat_t SAT_HI = sat_t'((64'sd1 <<< (CWE - 1)) - 64'sd1);
	localparam sat_t SAT_LO = sat_t'(64'sd0 - (64'sd1 <<< (CWE - 1)));

	typedef struct packed {
		logic                   hit;
		logic                   slide;
		logic                   degen;
		logic                   nvneg;
		logic [2:0]             nneg;
		stsl_pkg::coord_t [2:0] b;
	} side_t;

	// Vertex registers.
	logic [stsl_pkg::VTX_W-1:0] vtx_a_q, vtx_b_q, vtx_c_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_a_q <= '0;
			vtx_b_q <= '0;
			vtx_c_q <= '0;
		end else if (cfg.valid) begin
			unique case (stsl_pkg::cfg_reg_t'(cfg.index))
				stsl_pkg::REG_VERTEX_A: vtx_a_q <= cfg.data;
				stsl_pkg::REG_VERTEX_B: vtx_b_q <= cfg.data;
				stsl_pkg::REG_VERTEX_C: vtx_c_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// One enable moves every stage; it drops only when a finished result is not taken.
	logic              en;
	logic [PIPE_N-1:0] vld_s;

	assign en          = !vld_s[PIPE_N-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_N-2:0], in_ch.valid};
		end
	end

	stsl_pkg::in_item_t item;

	always_comb begin
		item.req_type = in_ch.req_type;
		item.start[0] = in_ch.start_x;
		item.start[1] = in_ch.start_y;
		item.start[2] = in_ch.start_z;
		item.move[0]  = in_ch.move_x;
		item.move[1]  = in_ch.move_y;
		item.move[2]  = in_ch.move_z;
	end

	// Stages one to five: the geometry front end.
	stsl_pkg::front_t fr;

	stsl_front #(.CWE(CWE)) u_front (
		.clk   (clk),
		.en    (en),
		.item  (item),
		.vtx_a (vtx_a_q),
		.vtx_b (vtx_b_q),
		.vtx_c (vtx_c_q),
		.res   (fr)
	);

	// Stage six: when N.M is negative, negate it and all numerators, so that the denominator is not negative.
	stsl_pkg::dot_t   uv_c;
	logic             neg_c;
	stsl_pkg::dot_t   nbp_s6, tnp_s6, unp_s6, vnp_s6, uvp_s6;
	logic             nbz_s6, nvneg_s6, req_s6, degen_s6;
	stsl_pkg::crs_t   n_s6 [3];
	stsl_pkg::nn_t    nn_s6;
	stsl_pkg::coord_t b_s6 [3];

	assign uv_c  = fr.un + fr.vn;
	assign neg_c = fr.nb[stsl_pkg::DOT_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			nbp_s6   <= neg_c ? -fr.nb : fr.nb;
			tnp_s6   <= neg_c ? -fr.tn : fr.tn;
			unp_s6   <= neg_c ? -fr.un : fr.un;
			vnp_s6   <= neg_c ? -fr.vn : fr.vn;
			uvp_s6   <= neg_c ? -uv_c : uv_c;
			nbz_s6   <= (fr.nb == '0);
			nvneg_s6 <= neg_c;
			req_s6   <= fr.req;
			degen_s6 <= fr.degen;
			nn_s6    <= fr.nn;
			for (int i = 0; i < 3; i++) begin
				n_s6[i] <= fr.n[i];
				b_s6[i] <= fr.b[i];
			end
		end
	end

	// Stage seven: the hit decision, borders included, and the normal's magnitudes.
	logic                        hit_s7, req_s7, degen_s7, nvneg_s7;
	logic [2:0]                  nneg_s7;
	logic [stsl_pkg::MAG_W-1:0]  nmag_s7 [3];
	logic [stsl_pkg::DOT_W-1:0]  nvmag_s7, tnp_s7;
	stsl_pkg::nn_t               nn_s7;
	stsl_pkg::coord_t            b_s7 [3];
	stsl_pkg::crs_t              nabs_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nabs_c[i] = n_s6[i][stsl_pkg::CRS_W-1] ? -n_s6[i] : n_s6[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s7   <= !nbz_s6 && (tnp_s6 >= 0) && (tnp_s6 <= nbp_s6) && (unp_s6 >= 0)
				&& (vnp_s6 >= 0) && (uvp_s6 <= nbp_s6);
			req_s7   <= req_s6;
			degen_s7 <= degen_s6;
			nvneg_s7 <= nvneg_s6;
			nvmag_s7 <= nbp_s6;
			tnp_s7   <= tnp_s6;
			nn_s7    <= nn_s6;
			for (int i = 0; i < 3; i++) begin
				nneg_s7[i] <= n_s6[i][stsl_pkg::CRS_W-1];
				nmag_s7[i] <= nabs_c[i][stsl_pkg::MAG_W-1:0];
				b_s7[i]    <= b_s6[i];
			end
		end
	end

	// Stage eight: |n_i| * |N.M| as two half-width partial products.
	pprod_t                     plo_s8 [3];
	pprod_t                     phi_s8 [3];
	logic [TNUM_W-1:0]          tnum_s8;
	logic [stsl_pkg::DOT_W-1:0] tden_s8;
	stsl_pkg::nn_t              nn_s8;
	side_t                      side_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				plo_s8[i] <= pprod_t'(nmag_s7[i])
					* pprod_t'(nvmag_s7[stsl_pkg::SPLIT_W-1:0]);
				phi_s8[i] <= pprod_t'(nmag_s7[i])
					* pprod_t'(nvmag_s7[stsl_pkg::DOT_W-1:stsl_pkg::SPLIT_W]);
				side_s8.b[i] <= b_s7[i];
			end
			tnum_s8       <= {tnp_s7, {TIME_FRAC_BITS{1'b0}}};
			tden_s8       <= nvmag_s7;
			nn_s8         <= nn_s7;
			side_s8.hit   <= hit_s7;
			side_s8.slide <= !degen_s7 && (req_s7 || hit_s7);
			side_s8.degen <= degen_s7;
			side_s8.nvneg <= nvneg_s7;
			side_s8.nneg  <= nneg_s7;
		end
	end

	// Stage nine: combine the partial products into the projection numerators.
	num_t                       num_s9 [3];
	logic [TNUM_W-1:0]          tnum_s9;
	logic [stsl_pkg::DOT_W-1:0] tden_s9;
	stsl_pkg::nn_t              nn_s9;
	side_t                      side_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s9[i] <= num_t'(plo_s8[i]) + (num_t'(phi_s8[i]) << stsl_pkg::SPLIT_W);
			end
			tnum_s9 <= tnum_s8;
			tden_s9 <= tden_s8;
			nn_s9   <= nn_s8;
			side_s9 <= side_s8;
		end
	end

	// Divider stages: t = floor(tn * 2^TIME_FRAC_BITS / nb) and the three projection terms.
	logic [TQB-1:0]            tq;
	logic [stsl_pkg::PQB-1:0]  pq [3];
	num_t                      prem [3];
	stsl_pkg::nn_t             pden [3];
	side_t                     side_sd [DEPTH];

	stsl_div #(
		.NW    (TNUM_W),
		.DW    (stsl_pkg::DOT_W),
		.QB    (TQB),
		.DEPTH (DEPTH)
	) u_tdiv (
		.clk   (clk),
		.en    (en),
		.num   (tnum_s9),
		.den   (tden_s9),
		.quo   (tq),
		.rem   (),
		.den_o ()
	);

	for (genvar g = 0; g < 3; g++) begin : g_pdiv
		stsl_div #(
			.NW    (stsl_pkg::NUM_W),
			.DW    (stsl_pkg::NN_W),
			.QB    (stsl_pkg::PQB),
			.DEPTH (DEPTH)
		) u_pdiv (
			.clk   (clk),
			.en    (en),
			.num   (num_s9[g]),
			.den   (nn_s9),
			.quo   (pq[g]),
			.rem   (prem[g]),
			.den_o (pden[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= side_s9;
			for (int j = 1; j < DEPTH; j++) begin
				side_sd[j] <= side_sd[j-1];
			end
		end
	end

	// Rounding stage: half a step or more in the remainder rounds the term away from zero; t is cleared on a miss.
	rnd_t  qr_sr [3];
	time_t time_sr;
	side_t side_sr;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				qr_sr[i] <= rnd_t'(pq[i])
					+ rnd_t'({prem[i], 1'b0} >= {1'b0, num_t'(pden[i])});
			end
			time_sr <= side_sd[DEPTH-1].hit ? time_t'(tq) : '0;
			side_sr <= side_sd[DEPTH-1];
		end
	end

	// Output stage: subtract the signed projection term and saturate, or pass the move unchanged when no slide is done.
	sat_t             diff_c [3];
	stsl_pkg::coord_t slid_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (side_sr.nneg[i] ^ side_sr.nvneg) begin
				diff_c[i] = sat_t'(side_sr.b[i]) + sat_t'({1'b0, qr_sr[i]});
			end else begin
				diff_c[i] = sat_t'(side_sr.b[i]) - sat_t'({1'b0, qr_sr[i]});
			end
			if (!side_sr.slide) begin
				slid_c[i] = side_sr.b[i];
			end else if (diff_c[i] > SAT_HI) begin
				slid_c[i] = stsl_pkg::coord_t'(SAT_HI);
			end else if (diff_c[i] < SAT_LO) begin
				slid_c[i] = stsl_pkg::coord_t'(SAT_LO);
			end else begin
				slid_c[i] = stsl_pkg::coord_t'(diff_c[i]);
			end
		end
	end

	logic             hit_so, degen_so;
	time_t            time_so;
	stsl_pkg::coord_t slid_so [3];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_so   <= side_sr.hit;
			degen_so <= side_sr.degen;
			time_so  <= time_sr;
			for (int i = 0; i < 3; i++) begin
				slid_so[i] <= slid_c[i];
			end
		end
	end

	assign out_ch.valid      = vld_s[PIPE_N-1];
	assign out_ch.hit        = hit_so;
	assign out_ch.hit_time   = time_so;
	assign out_ch.slid_x     = slid_so[0];
	assign out_ch.slid_y     = slid_so[1];
	assign out_ch.slid_z     = slid_so[2];
	assign out_ch.degenerate = degen_so;

	a_miss_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.hit |-> out_ch.hit_time == '0)
		else $error("hit_time is not zero on a miss");

	a_degen_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.degenerate |-> !out_ch.hit)
		else $error("degenerate triangle reported a hit");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[PIPE_N-1] && !out_ch.ready |=> $stable(vld_s))
		else $error("pipeline moved while the result was stalled");

endmodule
